### design/sed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared types and constants for the elevator scheduler and its testbench.
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam int CYL_W  = 16;
	localparam int MOVE_W = 17;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [ADDR_W-3:0] REG_LAST_CYL   = '0;
	localparam logic [CYL_W-1:0]  LAST_CYL_RESET = 16'd199;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_START = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_INS  = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_CALC = 6'b001000,
		ST_MOVE = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

endpackage

### design/sed_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is requested.
// ----------------------------------------------------------------------------
module sed_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/scan_elevator_disk_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN elevator disk scheduler
// Requests are kept sorted in a memory; a start item emits the head and then
// the requests in elevator order, each tagged with the total head movement.
// ----------------------------------------------------------------------------
// An add item inserts its cylinder into the sorted request memory by moving
// larger entries up one place, one memory entry per cycle. A start item scans
// the stored requests once to find the split around the head, computes the
// sweep end and direction in the calc state and the movement in the move
// state, and then streams count plus one results at one per cycle while the
// output side keeps up. Both phases go through the single memory port pair.
// Requests beyond MAX_REQUESTS are dropped and flagged as overflow on the
// next schedule.
module scan_elevator_disk_scheduler
	import sed_pkg::*;
#(
	parameter int MAX_REQUESTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [CYL_W-1:0]    cylinder,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CYL_W-1:0]    served_cylinder,
	output logic [MOVE_W-1:0]   total_movement,
	output logic                last,
	output logic                overflow
);

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              dropped_q;
	logic [CYL_W-1:0]  last_cyl_q;
	logic [CYL_W-1:0]  val_q;
	logic [AW-1:0]     j_q;
	logic [CW-1:0]     n_q;
	logic [AW-1:0]     sc_q;
	logic [CW-1:0]     nb_q;
	logic [CYL_W-1:0]  head_q;
	logic [CYL_W-1:0]  min_q;
	logic [CYL_W-1:0]  max_q;
	logic [CYL_W-1:0]  end_q;
	logic              down_q;
	logic              below_q;
	logic              upper_q;
	logic [MOVE_W-1:0] move_q;
	logic              ovf_q;
	logic              head_pend_q;
	logic              pend_q;
	logic [CW-1:0]     rd_k_q;
	logic              out_valid_q;
	logic [CYL_W-1:0]  out_cyl_q;
	logic [MOVE_W-1:0] out_move_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CYL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CYL_W-1:0]  ram_rdata;

	logic              cfg_wr;
	logic              in_acc;
	logic              add_acc;
	logic              start_acc;
	logic              has_room;
	logic              ins_shift;
	logic              ins_done;
	logic              scan_last;
	logic [CYL_W-1:0]  dist_c;
	logic [CYL_W-1:0]  end_c;
	logic [MOVE_W-1:0] move_c;
	logic              first_c;
	logic [CW-1:0]     emit_full_c;
	logic              out_free;
	logic              load_head;
	logic              load_ram;
	logic              last_ram;
	logic              issue;
	logic              sched_done;

	sed_ram #(
		.WIDTH (CYL_W),
		.DEPTH (MAX_REQUESTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[ADDR_W-1:2] == REG_LAST_CYL);

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_LAST_CYL) begin
			prdata = {{(DATA_W-CYL_W){1'b0}}, last_cyl_q};
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign add_acc   = in_acc && (req_type == REQ_ADD);
	assign start_acc = in_acc && (req_type == REQ_START);
	assign has_room  = (count_q < CW'(MAX_REQUESTS));

	assign ins_shift = (j_q != '0) && (ram_rdata > val_q);
	assign ins_done  = !ins_shift;
	assign scan_last = (sc_q == AW'(n_q - CW'(1)));

	assign dist_c = (head_q >= last_cyl_q) ? (head_q - last_cyl_q) : (last_cyl_q - head_q);

	always_comb begin
		end_c = last_cyl_q;
		if (head_q > end_c) begin
			end_c = head_q;
		end
		if ((n_q != '0) && (max_q > end_c)) begin
			end_c = max_q;
		end
	end

	always_comb begin
		if (down_q) begin
			if (below_q) begin
				move_c = MOVE_W'(head_q) + (upper_q ? MOVE_W'(max_q) : '0);
			end else begin
				move_c = upper_q ? MOVE_W'(max_q - head_q) : '0;
			end
		end else begin
			if (upper_q) begin
				move_c = MOVE_W'(end_q - head_q) + (below_q ? MOVE_W'(end_q - min_q) : '0);
			end else begin
				move_c = below_q ? MOVE_W'(head_q - min_q) : '0;
			end
		end
	end

	always_comb begin
		first_c = down_q ? (rd_k_q < nb_q) : (rd_k_q < CW'(n_q - nb_q));
		if (down_q) begin
			emit_full_c = first_c ? CW'(nb_q - rd_k_q - CW'(1)) : rd_k_q;
		end else begin
			emit_full_c = first_c ? CW'(nb_q + rd_k_q) : CW'(n_q - rd_k_q - CW'(1));
		end
	end

	assign out_free   = !out_valid_q || out_ready;
	assign load_head  = (state_q == ST_EMIT) && head_pend_q && out_free;
	assign load_ram   = (state_q == ST_EMIT) && !head_pend_q && pend_q && out_free;
	assign last_ram   = (rd_k_q == n_q);
	assign issue      = (state_q == ST_EMIT) && (rd_k_q != n_q) && (!pend_q || load_ram);
	assign sched_done = (load_head && (n_q == '0)) || (load_ram && last_ram);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (add_acc && has_room) begin
					if (count_q == '0) begin
						ram_we    = 1'b1;
						ram_wdata = cylinder;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = AW'(count_q - CW'(1));
					end
				end else if (start_acc && (count_q != '0)) begin
					ram_re = 1'b1;
				end
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				if (ins_shift) begin
					ram_wdata = ram_rdata;
					if (j_q > AW'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(j_q - AW'(2));
					end
				end
			end
			ST_SCAN: begin
				if (!scan_last) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(sc_q + AW'(1));
				end
			end
			ST_EMIT: begin
				ram_re    = issue;
				ram_raddr = emit_full_c[AW-1:0];
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			last_cyl_q  <= LAST_CYL_RESET;
			j_q         <= '0;
			n_q         <= '0;
			sc_q        <= '0;
			nb_q        <= '0;
			ovf_q       <= 1'b0;
			head_pend_q <= 1'b0;
			pend_q      <= 1'b0;
			rd_k_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				last_cyl_q <= pwdata[CYL_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (add_acc) begin
						if (has_room) begin
							count_q <= CW'(count_q + CW'(1));
							j_q     <= AW'(count_q);
							if (count_q != '0) begin
								state_q <= ST_INS;
							end
						end else begin
							dropped_q <= 1'b1;
						end
					end else if (start_acc) begin
						n_q       <= count_q;
						count_q   <= '0;
						ovf_q     <= dropped_q;
						dropped_q <= 1'b0;
						sc_q      <= '0;
						nb_q      <= '0;
						state_q   <= (count_q != '0) ? ST_SCAN : ST_CALC;
					end
				end
				ST_INS: begin
					if (ins_done) begin
						state_q <= ST_IDLE;
					end else begin
						j_q <= AW'(j_q - AW'(1));
					end
				end
				ST_SCAN: begin
					if (ram_rdata < head_q) begin
						nb_q <= CW'(nb_q + CW'(1));
					end
					if (scan_last) begin
						state_q <= ST_CALC;
					end else begin
						sc_q <= AW'(sc_q + AW'(1));
					end
				end
				ST_CALC: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					head_pend_q <= 1'b1;
					pend_q      <= 1'b0;
					rd_k_q      <= '0;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_head) begin
						head_pend_q <= 1'b0;
					end
					if (issue) begin
						pend_q <= 1'b1;
						rd_k_q <= CW'(rd_k_q + CW'(1));
					end else if (load_ram) begin
						pend_q <= 1'b0;
					end
					if (sched_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_head || load_ram) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_acc) begin
			val_q <= cylinder;
		end
		if (start_acc) begin
			head_q <= cylinder;
		end
		if (state_q == ST_SCAN) begin
			max_q <= ram_rdata;
			if (sc_q == '0) begin
				min_q <= ram_rdata;
			end
		end
		if (state_q == ST_CALC) begin
			end_q   <= end_c;
			down_q  <= (head_q <= dist_c);
			below_q <= (nb_q != '0);
			upper_q <= (n_q != '0) && (max_q > head_q);
		end
		if (state_q == ST_MOVE) begin
			move_q <= move_c;
		end
		if (load_head) begin
			out_cyl_q  <= head_q;
			out_move_q <= move_q;
			out_last_q <= (n_q == '0);
			out_ovf_q  <= ovf_q;
		end else if (load_ram) begin
			out_cyl_q  <= ram_rdata;
			out_move_q <= move_q;
			out_last_q <= last_ram;
			out_ovf_q  <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign served_cylinder = out_cyl_q;
	assign total_movement  = out_move_q;
	assign last            = out_last_q;
	assign overflow        = out_ovf_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REQUESTS))
		else $error("Request count exceeds the store depth.");

	a_pend_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_EMIT))
		else $error("Read data pending outside the emit phase.");

	a_reads_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rd_k_q <= n_q))
		else $error("More memory reads issued than stored requests.");

	a_empty_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		(load_head && (n_q == '0)) |=> (out_valid_q && out_last_q && (state_q == ST_IDLE)))
		else $error("A schedule without requests did not end on the head item.");
`endif

endmodule

### sim/scan_elevator_disk_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCAN elevator disk scheduler testbench
// Loads request batches and start items through the valid/ready input, checks
// every emitted cylinder, movement, last and overflow against an elevator
// schedule computed here, and changes the sweep end while idle between phases.
// ----------------------------------------------------------------------------
import sed_pkg::*;

localparam int MAX_REQ = 16;

typedef struct packed {
	logic [CYL_W-1:0]  cyl;
	logic [MOVE_W-1:0] move;
	logic              fin;
	logic              ovf;
} served_t;

class scan_schedule_checker;
	int unsigned last_cyl = LAST_CYL_RESET;
	int unsigned held_req[$];
	bit          dropped = 1'b0;
	served_t     pending_served[$];
	int          errors = 0;

	task report(string msg);
		errors++;
		$display("[%0t] %s", $time, msg);
	endtask

	function void build_schedule(int unsigned head);
		int unsigned srt[MAX_REQ];
		int unsigned n, nb, i, j, v, maxv, minv, endv, end_gap, mv;
		bit up_side, lo_side, down_first;
		int unsigned order[$];
		served_t e;
		n = held_req.size();
		for (i = 0; i < n; i++) begin
			v = held_req[i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		nb = 0;
		while (nb < n && srt[nb] < head) nb++;
		maxv = (n > 0) ? srt[n-1] : head;
		minv = (n > 0) ? srt[0] : head;
		up_side = (n > 0) && (maxv > head);
		lo_side = (nb > 0);
		endv = last_cyl;
		if (head > endv) endv = head;
		if (maxv > endv) endv = maxv;
		end_gap = (head >= last_cyl) ? head - last_cyl : last_cyl - head;
		down_first = (head <= end_gap);
		if (down_first) begin
			if (lo_side) mv = head + (up_side ? maxv : 0);
			else mv = up_side ? maxv - head : 0;
		end else begin
			if (up_side) mv = (endv - head) + (lo_side ? endv - minv : 0);
			else mv = lo_side ? head - minv : 0;
		end
		order.push_back(head);
		if (down_first) begin
			for (i = nb; i > 0; i--) order.push_back(srt[i-1]);
			for (i = nb; i < n; i++) order.push_back(srt[i]);
		end else begin
			for (i = nb; i < n; i++) order.push_back(srt[i]);
			for (i = nb; i > 0; i--) order.push_back(srt[i-1]);
		end
		foreach (order[k]) begin
			e.cyl  = CYL_W'(order[k]);
			e.move = MOVE_W'(mv);
			e.fin  = (k == order.size() - 1);
			e.ovf  = dropped;
			pending_served.push_back(e);
		end
		held_req.delete();
		dropped = 1'b0;
	endfunction

	function void take_request(logic rt, logic [CYL_W-1:0] cyl);
		if (rt == REQ_START) begin
			build_schedule(cyl);
		end else if (held_req.size() < MAX_REQ) begin
			held_req.push_back(cyl);
		end else begin
			dropped = 1'b1;
		end
	endfunction

	task check_served(logic [CYL_W-1:0] cyl, logic [MOVE_W-1:0] mv, logic fin, logic ovf);
		served_t e;
		if (pending_served.size() == 0) begin
			report($sformatf("unexpected result cylinder %0d", cyl));
		end else begin
			e = pending_served.pop_front();
			if (cyl !== e.cyl)
				report($sformatf("served_cylinder %0d, expected %0d", cyl, e.cyl));
			if (mv !== e.move)
				report($sformatf("total_movement %0d, expected %0d", mv, e.move));
			if (fin !== e.fin)
				report($sformatf("last %b, expected %b", fin, e.fin));
			if (ovf !== e.ovf)
				report($sformatf("overflow %b, expected %b", ovf, e.ovf));
		end
	endtask
endclass

module scan_elevator_disk_scheduler_tb;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 2 * MAX_REQ + 8;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [CYL_W-1:0]   cylinder;
	logic               out_valid;
	logic               out_ready;
	logic [CYL_W-1:0]   served_cylinder;
	logic [MOVE_W-1:0]  total_movement;
	logic               last;
	logic               overflow;

	scan_schedule_checker sb;
	int idle_pct;
	int stall_pct;
	int cycles;

	scan_elevator_disk_scheduler #(
		.MAX_REQUESTS(MAX_REQ)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.cylinder(cylinder),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.served_cylinder(served_cylinder),
		.total_movement(total_movement),
		.last(last),
		.overflow(overflow)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_served(served_cylinder, total_movement, last, overflow);
		end
	end

	task send_item(input logic rt, input logic [CYL_W-1:0] cyl);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		cylinder <= cyl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.take_request(rt, cyl);
	endtask

	task wait_schedules_done;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_served.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [CYL_W-1:0] pick_cyl(int unsigned lc);
		case ($urandom_range(3))
			0: return CYL_W'($urandom_range(65535));
			1: return CYL_W'($urandom_range(lc));
			2: begin
				case ($urandom_range(2))
					0: return '0;
					1: return CYL_W'(lc);
					default: return '1;
				endcase
			end
			default: return CYL_W'($urandom_range(lc >> 3));
		endcase
	endfunction

	function automatic logic [CYL_W-1:0] pick_head(int unsigned lc);
		case ($urandom_range(5))
			0: return '0;
			1: return CYL_W'(lc);
			2: return CYL_W'(lc / 2);
			3: return (lc / 2 + 1 > 65535) ? '1 : CYL_W'(lc / 2 + 1);
			4: return CYL_W'($urandom_range(lc));
			default: return CYL_W'($urandom_range(65535));
		endcase
	endfunction

	task run_phase(input int unsigned lc, input int sidle, input int rstall, input int target);
		int sent;
		int n;
		int r;
		logic [CYL_W-1:0] head;
		wait_schedules_done();
		apb_write({REG_LAST_CYL, 2'b00}, lc);
		sb.last_cyl = lc;
		idle_pct = sidle;
		stall_pct = rstall;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(99);
			if (r < 70) n = $urandom_range(1, 8);
			else if (r < 80) n = 0;
			else if (r < 90) n = $urandom_range(9, MAX_REQ);
			else n = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
			head = pick_head(lc);
			repeat (n) begin
				if ($urandom_range(7) == 0) send_item(REQ_ADD, head);
				else send_item(REQ_ADD, pick_cyl(lc));
			end
			send_item(REQ_START, head);
			sent += n + 1;
		end
	endtask

	initial begin
		sb = new;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = REQ_ADD;
		cylinder = '0;
		out_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(REQ_START, 16'd0);
		send_item(REQ_ADD, 16'd0);
		send_item(REQ_ADD, 16'd65535);
		send_item(REQ_ADD, 16'd100);
		send_item(REQ_ADD, 16'd100);
		send_item(REQ_START, 16'd100);
		send_item(REQ_ADD, 16'd5);
		send_item(REQ_ADD, 16'd300);
		send_item(REQ_ADD, 16'd150);
		send_item(REQ_START, 16'd65535);
		send_item(REQ_ADD, 16'd50);
		send_item(REQ_ADD, 16'd20);
		send_item(REQ_START, 16'd199);
		send_item(REQ_ADD, 16'd180);
		send_item(REQ_ADD, 16'd40);
		send_item(REQ_ADD, 16'd0);
		send_item(REQ_START, 16'd99);
		send_item(REQ_ADD, 16'd99);
		send_item(REQ_START, 16'd99);
		send_item(REQ_ADD, 16'd65535);
		send_item(REQ_START, 16'd0);

		run_phase(65535, 0, 0, 82);
		run_phase(1, 76, 0, 82);
		run_phase($urandom_range(2, 65534), 0, 76, 82);
		run_phase($urandom_range(100, 1000), 26, 26, 82);

		wait_schedules_done();
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

### sim.f
design/sed_pkg.sv
design/sed_ram.sv
design/scan_elevator_disk_scheduler.sv
sim/scan_elevator_disk_scheduler_tb.sv
